### src/cigar_deletion_offset_walker_assert.svh
// assertion macros for the cigar deletion offset walker rtl
`ifndef CIGAR_DELETION_OFFSET_WALKER_ASSERT_SVH
`define CIGAR_DELETION_OFFSET_WALKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CDOW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdow same-cycle check failed");

// next-cycle implication, disabled during reset
`define CDOW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdow next-cycle check failed");

`endif

### src/cdow_pkg.sv
// types, constants and codes for the cigar deletion offset walker
package cdow_pkg;

   // widths
   localparam int LEN_BITS = 20;
   localparam int LIMIT_W  = 20;
   localparam int OFF_W    = 21;
   localparam int RUN_W    = LEN_BITS + 4;
   localparam int SUM_W    = LEN_BITS + 1;
   localparam int TOT_W    = LEN_BITS + 2;
   localparam int DIFF_W   = (LEN_BITS + 2 > OFF_W) ? LEN_BITS + 2 : OFF_W;
   localparam int OFF_MAX  = 1048575;

   // saturation ceiling for run length and sums
   localparam logic [LEN_BITS-1:0] SUM_MAX = {LEN_BITS{1'b1}};

   // characters of interest
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SOFT   = 8'h53;
   localparam logic [7:0] CHAR_MATCH  = 8'h4D;
   localparam logic [7:0] CHAR_DELETE = 8'h44;
   localparam logic [7:0] CHAR_INSERT = 8'h49;
   localparam logic [3:0] RADIX       = 4'd10;

   // classified operation
   typedef enum logic [2:0] {
      OP_DIGIT,
      OP_SKIP,
      OP_MATCH,
      OP_DELETE,
      OP_INSERT,
      OP_BAD
   } op_type;

   // request payload
   typedef struct packed {
      logic [7:0]         cigar_char;
      logic [LIMIT_W-1:0] ref_limit;
      logic               end_of_string;
   } req_type;

   // response payload
   typedef struct packed {
      logic signed [OFF_W-1:0] deletion_offset;
      logic                    in_deletion;
      logic                    bad_char_seen;
   } rsp_type;

   // classified item passed from front to back
   typedef struct packed {
      op_type             op;
      logic [3:0]         digit;
      logic [LIMIT_W-1:0] ref_limit;
      logic               end_of_string;
   } item_type;

endpackage

### src/cdow_front.sv
// front end: accepts requests and classifies each character
module cdow_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  cdow_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output cdow_pkg::item_type push_item
);
   import cdow_pkg::*;

   op_type op;

   // character classification
   always_comb begin
      case (req_data.cigar_char) inside
         [CHAR_ZERO:CHAR_NINE]: op = OP_DIGIT;
         CHAR_SOFT:             op = OP_SKIP;
         CHAR_MATCH:            op = OP_MATCH;
         CHAR_DELETE:           op = OP_DELETE;
         CHAR_INSERT:           op = OP_INSERT;
         default:               op = OP_BAD;
      endcase
   end

   // pack the classified item
   always_comb begin
      push_item.op            = op;
      push_item.digit         = 4'(req_data.cigar_char - CHAR_ZERO);
      push_item.ref_limit     = req_data.ref_limit;
      push_item.end_of_string = req_data.end_of_string;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

### src/cdow_queue.sv
// two-entry queue between front and back
module cdow_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  cdow_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output cdow_pkg::item_type pop_item
);
   import cdow_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### src/cdow_back.sv
// back end: run length, sums, stop detection and the response register
`include "cigar_deletion_offset_walker_assert.svh"

module cdow_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  cdow_pkg::item_type item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output cdow_pkg::rsp_type  rsp_data
);
   import cdow_pkg::*;

   logic [LEN_BITS-1:0] run_ff, run_in;
   logic [LEN_BITS-1:0] match_ff, match_in;
   logic [LEN_BITS-1:0] delete_ff, delete_in;
   logic [LEN_BITS-1:0] insert_ff, insert_in;
   logic [LEN_BITS-1:0] limit_ff, limit_in;
   logic                stopped_ff, stopped_in;
   logic                stop_del_ff, stop_del_in;
   logic                bad_ff, bad_in;
   logic                start_ff, start_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [LEN_BITS-1:0] run_base, match_base, delete_base, insert_base;
   logic                stopped_base;
   logic [RUN_W-1:0]    run_scaled;
   logic [SUM_W-1:0]    add_a, add_sum;
   logic [LEN_BITS-1:0] add_sat;
   logic signed [TOT_W-1:0]  total;
   logic signed [DIFF_W-1:0] diff, diff_clamped;
   logic                accept;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign accept     = item_valid && item_ready;

   // string start clears the working state
   always_comb begin
      run_base     = start_ff ? '0 : run_ff;
      match_base   = start_ff ? '0 : match_ff;
      delete_base  = start_ff ? '0 : delete_ff;
      insert_base  = start_ff ? '0 : insert_ff;
      stopped_base = start_ff ? 1'b0 : stopped_ff;
   end

   // decimal run step and shared saturating adder
   always_comb begin
      run_scaled = (RUN_W'(run_base) << 3) + (RUN_W'(run_base) << 1) + RUN_W'(item.digit);
      case (item.op)
         OP_MATCH:  add_a = SUM_W'(match_base);
         OP_DELETE: add_a = SUM_W'(delete_base);
         default:   add_a = SUM_W'(insert_base);
      endcase
      add_sum = add_a + SUM_W'(run_base);
      add_sat = add_sum[SUM_W-1] ? SUM_MAX : add_sum[LEN_BITS-1:0];
   end

   // per-character state update
   always_comb begin
      run_in      = run_ff;
      match_in    = match_ff;
      delete_in   = delete_ff;
      insert_in   = insert_ff;
      limit_in    = limit_ff;
      stopped_in  = stopped_ff;
      stop_del_in = stop_del_ff;
      bad_in      = bad_ff;
      start_in    = start_ff;
      total       = '0;
      if (accept) begin
         run_in      = run_base;
         match_in    = match_base;
         delete_in   = delete_base;
         insert_in   = insert_base;
         stopped_in  = stopped_base;
         if (start_ff) begin
            limit_in    = LEN_BITS'(item.ref_limit);
            stop_del_in = 1'b0;
            bad_in      = 1'b0;
         end
         if (!stopped_base) begin
            case (item.op)
               OP_DIGIT: begin
                  run_in = (run_scaled > RUN_W'(SUM_MAX)) ? SUM_MAX
                                                          : run_scaled[LEN_BITS-1:0];
               end
               OP_SKIP: begin
                  run_in = '0;
               end
               OP_MATCH: begin
                  match_in = add_sat;
                  run_in   = '0;
               end
               OP_DELETE: begin
                  delete_in = add_sat;
                  run_in    = '0;
               end
               OP_INSERT: begin
                  insert_in = add_sat;
                  run_in    = '0;
               end
               default: begin
                  bad_in = 1'b1;
               end
            endcase
            // stop check after an M or D
            total = $signed(TOT_W'(match_in)) + $signed(TOT_W'(delete_in))
                  - $signed(TOT_W'(insert_in));
            if ((item.op == OP_MATCH || item.op == OP_DELETE) &&
                (total >= $signed(TOT_W'(start_ff ? LEN_BITS'(item.ref_limit)
                                                   : limit_ff)))) begin
               stopped_in  = 1'b1;
               stop_del_in = (item.op == OP_DELETE);
            end
         end
         start_in = item.end_of_string;
      end
   end

   // response formation from the updated sums
   always_comb begin
      diff = $signed(DIFF_W'(delete_in)) - $signed(DIFF_W'(insert_in));
      if (diff > $signed(DIFF_W'(OFF_MAX))) begin
         diff_clamped = $signed(DIFF_W'(OFF_MAX));
      end else if (diff < -$signed(DIFF_W'(OFF_MAX))) begin
         diff_clamped = -$signed(DIFF_W'(OFF_MAX));
      end else begin
         diff_clamped = diff;
      end
      rsp_in.deletion_offset = stop_del_in ? '0 : OFF_W'(diff_clamped);
      rsp_in.in_deletion     = stop_del_in;
      rsp_in.bad_char_seen   = bad_in;
      if (accept && item.end_of_string) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= '0;
         match_ff     <= '0;
         delete_ff    <= '0;
         insert_ff    <= '0;
         limit_ff     <= '0;
         stopped_ff   <= 1'b0;
         stop_del_ff  <= 1'b0;
         bad_ff       <= 1'b0;
         start_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         match_ff     <= match_in;
         delete_ff    <= delete_in;
         insert_ff    <= insert_in;
         limit_ff     <= limit_in;
         stopped_ff   <= stopped_in;
         stop_del_ff  <= stop_del_in;
         bad_ff       <= bad_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept && item.end_of_string) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `CDOW_ASSERT_NOW(a_del_implies_stop, clock, reset, stop_del_ff, stopped_ff)
   `CDOW_ASSERT_NOW(a_del_offset_zero, clock, reset, rsp_valid_ff && rsp_ff.in_deletion,
      rsp_ff.deletion_offset == '0)
   `CDOW_ASSERT_NEXT(a_sums_frozen, clock, reset, accept && stopped_ff && !start_ff,
      $stable(match_ff) && $stable(delete_ff) && $stable(insert_ff))
   `CDOW_ASSERT_NEXT(a_rearm_on_end, clock, reset, accept && item.end_of_string,
      start_ff && rsp_valid_ff)

endmodule

### src/cigar_deletion_offset_walker.sv
// top level of the cigar deletion offset walker
//
// usage:
//   req channel (req_valid, req_ready, req_data) takes one cigar character a
//   cycle with its reference limit and an end-of-string mark; the limit is
//   sampled on the first character of each string.
//   rsp channel (rsp_valid, rsp_ready, rsp_data) gives one response per
//   string, on the character marked end_of_string: deletion offset, the
//   in-deletion flag and the bad-character flag.
// path: the final character is registered in the queue entry, then the back
//   end takes it and registers the response that drives rsp_valid.
// throughput: one character per cycle unless a response stalls, set by the
//   combinational run, sum and stop update in the back end.
// reset: synchronous, active high; clears the queue, the sums and the
//   response valid flag, and arms the walker for the start of a string.
// stall: while a response waits for rsp_ready the back end holds, the
//   two-entry queue fills, and req_ready drops once it is full.
module cigar_deletion_offset_walker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cdow_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdow_pkg::rsp_type rsp_data
);
   import cdow_pkg::*;

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   // classify characters
   cdow_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // decouple front from back
   cdow_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // walk and respond
   cdow_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item       (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
